// ----- hw/rtl/colon_separated_integer_line_parser_core_macros.svh -----
// Assertion macros shared by the parser RTL.
`ifndef COLON_SEPARATED_INTEGER_LINE_PARSER_CORE_MACROS_SVH
`define COLON_SEPARATED_INTEGER_LINE_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define CSPL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define CSPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSPL_ASSERT(lbl, clk, rst, prop, msg)
`define CSPL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/cspl_pkg.sv -----
`timescale 1ns / 1ps

package cspl_pkg;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam int unsigned IDX_W   = 4;
  localparam int unsigned MAG_W   = 30;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned ODATA_W = 40;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [IDX_W-1:0]        field_index;
    logic signed [VAL_W-1:0] field_value;
    logic                    last_of_message;
    logic                    too_many_fields;
  } result_t;

endpackage

// ----- hw/rtl/cspl_field_conv.sv -----
`timescale 1ns / 1ps

module cspl_field_conv #(
  parameter int unsigned MAX_FIELDS      = 10,
  parameter int unsigned MAX_FIELD_CHARS = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output cspl_pkg::result_t res
);
  import cspl_pkg::*;

  localparam int unsigned FC_W = $clog2(MAX_FIELDS + 1);
  localparam int unsigned CC_W = $clog2(MAX_FIELD_CHARS + 1);

  logic [MAG_W-1:0] magnitude, magnitude_next;
  logic             negative, negative_next;
  phase_t           phase, phase_next;
  logic [CC_W-1:0]  char_count, char_count_next;
  logic [FC_W-1:0]  field_count, field_count_next;

  logic             is_nl, is_blank, is_digit, over;
  logic [MAG_W-1:0] mag_x10;
  logic [MAG_W-1:0] digit_val;
  logic [VAL_W-1:0] mag_ext;

  always_comb begin
    is_nl     = (rx_byte == CHAR_NEWLINE);
    res_valid = (rx_byte == CHAR_COLON) || is_nl;
    is_blank  = (rx_byte == 8'h20) || (rx_byte == 8'h09) || (rx_byte == 8'h0B) ||
                (rx_byte == 8'h0C) || (rx_byte == 8'h0D);
    is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    digit_val = {{(MAG_W-4){1'b0}}, rx_byte[3:0]};
    mag_x10   = {magnitude[MAG_W-4:0], 3'b000} + {magnitude[MAG_W-2:0], 1'b0};
    over      = (field_count >= FC_W'(MAX_FIELDS));
    mag_ext   = {1'b0, magnitude};

    res.field_index     = over ? IDX_W'(MAX_FIELDS - 1) : IDX_W'(field_count);
    res.field_value     = negative ? (VAL_W'(0) - mag_ext) : mag_ext;
    res.last_of_message = is_nl;
    res.too_many_fields = over;
  end

  always_comb begin
    magnitude_next   = magnitude;
    negative_next    = negative;
    phase_next       = phase;
    char_count_next  = char_count;
    field_count_next = field_count;
    if (take) begin
      if (res_valid) begin
        magnitude_next  = '0;
        negative_next   = 1'b0;
        phase_next      = PH_SKIP;
        char_count_next = '0;
        if (is_nl) begin
          field_count_next = '0;
        end else if (!over) begin
          field_count_next = field_count + FC_W'(1);
        end
      end else if (char_count < CC_W'(MAX_FIELD_CHARS)) begin
        char_count_next = char_count + CC_W'(1);
        unique case (phase)
          PH_SKIP: begin
            if (!is_blank) begin
              priority if (rx_byte == CHAR_PLUS) begin
                phase_next = PH_DIGITS;
              end else if (rx_byte == CHAR_MINUS) begin
                negative_next = 1'b1;
                phase_next    = PH_DIGITS;
              end else if (is_digit) begin
                magnitude_next = digit_val;
                phase_next     = PH_DIGITS;
              end else begin
                phase_next = PH_STOP;
              end
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              magnitude_next = mag_x10 + digit_val;
            end else begin
              phase_next = PH_STOP;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude   <= '0;
      negative    <= 1'b0;
      phase       <= PH_SKIP;
      char_count  <= '0;
      field_count <= '0;
    end else begin
      magnitude   <= magnitude_next;
      negative    <= negative_next;
      phase       <= phase_next;
      char_count  <= char_count_next;
      field_count <= field_count_next;
    end
  end

endmodule

// ----- hw/rtl/cspl_out_reg.sv -----
`timescale 1ns / 1ps

module cspl_out_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  cspl_pkg::result_t                res,
  output logic                             out_free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cspl_pkg::ODATA_W-1:0]     m_tdata,
  output logic                             m_tlast,
  output logic                             m_tuser
);
  import cspl_pkg::*;

  result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {{(ODATA_W - IDX_W - VAL_W){1'b0}}, held.field_value, held.field_index};
  assign m_tlast = held.last_of_message;
  assign m_tuser = held.too_many_fields;

endmodule

// ----- hw/rtl/colon_separated_integer_line_parser_core.sv -----
`timescale 1ns / 1ps
`include "colon_separated_integer_line_parser_core_macros.svh"

// Colon-separated decimal line parser. Bytes of a command line arrive one
// word at a time on the s_ side; fields are split at ':' and a message ends
// at newline. Each field is read like atoi (leading blanks skipped, optional
// sign, digits up to the first other byte, empty gives 0) and one result word
// leaves on the m_ side for every ':' or newline: field index, signed value,
// tlast on the newline field and tuser when the message ran past MAX_FIELDS
// fields (index then stays at MAX_FIELDS-1). Bytes past MAX_FIELD_CHARS in a
// field are ignored. Throughput is one byte per cycle while no delimiter
// waits: the byte sits in an input register, and the field state and the
// result register update from it. Only a delimiter byte waits on a stalled
// result register; other bytes pass.
module colon_separated_integer_line_parser_core #(
  parameter int unsigned MAX_FIELDS      = 10,  // 2..15
  parameter int unsigned MAX_FIELD_CHARS = 9    // 1..9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cspl_pkg::ODATA_W-1:0] m_tdata,   // [3:0] field_index, [34:4] field_value
  output logic                         m_tlast,   // last_of_message
  output logic                         m_tuser    // [0] too_many_fields
);
  import cspl_pkg::*;

  // input word register
  logic       in_valid;
  logic [7:0] in_byte;

  logic    take;
  logic    is_delim;
  logic    out_free;
  result_t res;

  // A delimiter needs room in the result register; anything else only
  // updates field state and can always go.
  assign take     = in_valid && (!is_delim || out_free);
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  cspl_field_conv #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (in_byte),
    .res_valid (is_delim),
    .res       (res)
  );

  cspl_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take && is_delim),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Overflowed fields always report the last slot.
  `CSPL_ASSERT(a_over_idx, clk, rst, m_tvalid && m_tuser |-> m_tdata[3:0] == 4'(MAX_FIELDS - 1), "overflow index wrong")
  // Index never passes the last slot.
  `CSPL_ASSERT(a_idx_range, clk, rst, m_tvalid |-> m_tdata[3:0] <= 4'(MAX_FIELDS - 1), "index out of range")
  // Input stalls only with a delimiter waiting on a stalled result.
  `CSPL_ASSERT(a_stall_cause, clk, rst, !s_tready |-> in_valid && is_delim && m_tvalid && !m_tready, "spurious input stall")
  // Reset leaves no result pending.
  `CSPL_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import cspl_pkg::*;

  localparam int unsigned N_FIELDS     = 10;
  localparam int unsigned N_CHARS      = 9;
  localparam int unsigned RANDOM_BYTES = 900;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HIGH  = 8'hFF;

  typedef struct {
    logic [7:0] ch;
    bit         known;  // res typed in below
    result_t    res;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [ODATA_W-1:0]   m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;

  // parser state mirror
  logic [MAG_W-1:0]     acc_mag;
  logic                 acc_neg;
  phase_t               acc_phase;
  int unsigned          acc_chars;
  int unsigned          acc_fields;

  result_t              pending_fields[$];
  int unsigned          mismatches;
  int unsigned          bytes_sent;
  int unsigned          burst_left;
  int unsigned          idle_cycles;

  // Directed pass: empty field, over-long field of nines, sign after sign,
  // blank + negative + NUL stop, high byte stop on the closing field.
  dir_row_t directed_rows [0:23] = '{
    '{CHAR_COLON,   1'b1, '{4'd0, 31'sd0, 1'b0, 1'b0}},
    '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0},
    '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0},
    '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0}, '{8'h39, 1'b0, '0},
    '{8'h39, 1'b0, '0},
    '{CHAR_COLON,   1'b1, '{4'd1, 31'sd999999999, 1'b0, 1'b0}},
    '{CHAR_PLUS,    1'b0, '0},
    '{CHAR_MINUS,   1'b0, '0},
    '{8'h35,        1'b0, '0},
    '{CHAR_NEWLINE, 1'b1, '{4'd2, 31'sd0, 1'b1, 1'b0}},
    '{CHAR_CR,      1'b0, '0},
    '{CHAR_MINUS,   1'b0, '0},
    '{8'h31,        1'b0, '0},
    '{CHAR_NUL,     1'b0, '0},
    '{8'h39,        1'b0, '0},
    '{CHAR_COLON,   1'b0, '0},
    '{CHAR_HIGH,    1'b0, '0},
    '{CHAR_NEWLINE, 1'b1, '{4'd1, 31'sd0, 1'b1, 1'b0}}
  };

  colon_separated_integer_line_parser_core #(
    .MAX_FIELDS      (N_FIELDS),
    .MAX_FIELD_CHARS (N_CHARS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_CR};
  endfunction

  task automatic clear_field();
    acc_mag   = '0;
    acc_neg   = 1'b0;
    acc_phase = PH_SKIP;
    acc_chars = 0;
  endtask

  // Advance the parser mirror by one byte; fired when a field closes.
  task automatic parse_byte(input logic [7:0] c, output bit fired, output result_t r);
    bit         digit;
    logic [3:0] d;
    fired = 1'b0;
    r     = '0;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d     = 4'(c - CHAR_ZERO);
    if (c == CHAR_COLON || c == CHAR_NEWLINE) begin
      fired             = 1'b1;
      r.too_many_fields = (acc_fields >= N_FIELDS);
      r.field_index     = r.too_many_fields ? IDX_W'(N_FIELDS - 1) : IDX_W'(acc_fields);
      r.field_value     = acc_neg ? -$signed({1'b0, acc_mag}) : $signed({1'b0, acc_mag});
      r.last_of_message = (c == CHAR_NEWLINE);
      if (c == CHAR_NEWLINE) begin
        acc_fields = 0;
      end else if (acc_fields < N_FIELDS) begin
        acc_fields++;
      end
      clear_field();
    end else if (acc_chars < N_CHARS) begin
      acc_chars++;
      case (acc_phase)
        PH_SKIP: begin
          if (!is_blank(c)) begin
            if (c == CHAR_PLUS) begin
              acc_phase = PH_DIGITS;
            end else if (c == CHAR_MINUS) begin
              acc_neg   = 1'b1;
              acc_phase = PH_DIGITS;
            end else if (digit) begin
              acc_mag   = MAG_W'(d);
              acc_phase = PH_DIGITS;
            end else begin
              acc_phase = PH_STOP;
            end
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            acc_mag = MAG_W'(acc_mag * 10 + d);
          end else begin
            acc_phase = PH_STOP;
          end
        end
        default: ;
      endcase
    end
  endtask

  // Drive one byte at the falling edge, hold until taken, then predict.
  // known/typed let a directed row supply its own expectation.
  task automatic send_word(input logic [7:0] b, input bit known = 1'b0,
                           input result_t typed = '0);
    bit      fired;
    result_t r;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    parse_byte(b, fired, r);
    if (known) begin
      pending_fields.push_back(typed);
    end else if (fired) begin
      pending_fields.push_back(r);
    end
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Sender holds off until every expected field has come out.
  task automatic drain_pause();
    s_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_field();
    logic [7:0] b;
    int unsigned n;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 4))
          0: b = CHAR_SPACE;
          1: b = CHAR_TAB;
          2: b = CHAR_VT;
          3: b = CHAR_FF;
          default: b = CHAR_CR;
        endcase
        send_word(b);
      end
    end
    case ($urandom_range(0, 3))
      0: send_word(CHAR_PLUS);
      1: send_word(CHAR_MINUS);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: n = 0;
      1, 2, 3, 4, 5, 6: n = $urandom_range(1, 5);
      default: n = $urandom_range(6, 11);
    endcase
    repeat (n) send_word(CHAR_ZERO + 8'($urandom_range(0, 9)));
    // stray non-delimiter byte that often stops the conversion, sometimes followed by digits
    if ($urandom_range(0, 5) == 0) begin
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_COLON || b == CHAR_NEWLINE);
      send_word(b);
      repeat ($urandom_range(0, 3)) send_word(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic send_message();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(N_FIELDS, N_FIELDS + 4)
                                    : $urandom_range(1, 5);
    for (int unsigned i = 0; i < n; i++) begin
      send_field();
      send_word((i == n - 1) ? CHAR_NEWLINE : CHAR_COLON);
    end
  endtask

  // Receiver: ready pattern changes mode every stretch of cycles.
  initial begin
    int unsigned mode;
    int unsigned phase_cnt;
    m_tready  = 1'b0;
    phase_cnt = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        phase_cnt++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) == 0);
          default: m_tready <= (phase_cnt % 16) < 10;
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    logic [IDX_W-1:0]        got_idx;
    logic signed [VAL_W-1:0] got_val;
    got_idx = m_tdata[IDX_W-1:0];
    got_val = m_tdata[IDX_W+VAL_W-1:IDX_W];
    if (!rst && m_tvalid && m_tready) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected field: idx %0d val %0d last %0b over %0b",
                 $time, got_idx, got_val, m_tlast, m_tuser);
        mismatches++;
      end else begin
        want = pending_fields.pop_front();
        if (got_idx !== want.field_index || got_val !== want.field_value ||
            m_tlast !== want.last_of_message || m_tuser !== want.too_many_fields) begin
          $display("%0t: mismatch: expected idx %0d val %0d last %0b over %0b, got idx %0d val %0d last %0b over %0b",
                   $time, want.field_index, want.field_value, want.last_of_message,
                   want.too_many_fields, got_idx, got_val, m_tlast, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    mismatches  = 0;
    bytes_sent  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    acc_fields  = 0;
    clear_field();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].ch, directed_rows[i].known, directed_rows[i].res);
    end
    drain_pause();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        // raw noise, delimiters included
        repeat ($urandom_range(1, 16)) send_word(8'($urandom_range(0, 255)));
      end else begin
        send_message();
      end
      if ($urandom_range(0, 30) == 0) drain_pause();
    end

    s_tvalid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_fields.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- colon_separated_integer_line_parser_core.f -----
+incdir+hw/rtl
hw/rtl/cspl_pkg.sv
hw/rtl/cspl_field_conv.sv
hw/rtl/cspl_out_reg.sv
hw/rtl/colon_separated_integer_line_parser_core.sv
tb/sv/testbench.sv
